// ----- rtl/core/idr_pkg.sv -----
// Shared types, constants, microcode and helper functions of the dead reckoning unit.
package idr_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int TRIG_ITER_DEF  = 16;
    localparam int ATAN_COUNT     = 24;
    localparam int TRIG_SHIFT     = 30;

    localparam int GRAV_W  = 21;
    localparam int ANG_W   = 34;
    localparam int PROD_W  = 2 * ANG_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int ID_W    = 6;
    localparam int KIND_W  = 4;
    localparam int STEP_W  = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 21'd642908;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd843314856;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032875;

    // operand / destination register ids of the back end
    localparam logic [ID_W-1:0] ID_DT   = 6'd0;
    localparam logic [ID_W-1:0] ID_ACCY = 6'd1;
    localparam logic [ID_W-1:0] ID_ACCZ = 6'd2;
    localparam logic [ID_W-1:0] ID_WX   = 6'd3;
    localparam logic [ID_W-1:0] ID_WY   = 6'd4;
    localparam logic [ID_W-1:0] ID_WZ   = 6'd5;
    localparam logic [ID_W-1:0] ID_VX   = 6'd6;
    localparam logic [ID_W-1:0] ID_VY   = 6'd7;
    localparam logic [ID_W-1:0] ID_VZ   = 6'd8;
    localparam logic [ID_W-1:0] ID_CX   = 6'd9;
    localparam logic [ID_W-1:0] ID_CY   = 6'd10;
    localparam logic [ID_W-1:0] ID_CZ   = 6'd11;
    localparam logic [ID_W-1:0] ID_RX   = 6'd12;
    localparam logic [ID_W-1:0] ID_RY   = 6'd13;
    localparam logic [ID_W-1:0] ID_RZ   = 6'd14;
    localparam logic [ID_W-1:0] ID_PX   = 6'd15;
    localparam logic [ID_W-1:0] ID_PY   = 6'd16;
    localparam logic [ID_W-1:0] ID_PZ   = 6'd17;
    localparam logic [ID_W-1:0] ID_SA   = 6'd18;
    localparam logic [ID_W-1:0] ID_CA   = 6'd19;
    localparam logic [ID_W-1:0] ID_SB   = 6'd20;
    localparam logic [ID_W-1:0] ID_CB   = 6'd21;
    localparam logic [ID_W-1:0] ID_SG   = 6'd22;
    localparam logic [ID_W-1:0] ID_CG   = 6'd23;
    localparam logic [ID_W-1:0] ID_T    = 6'd24;
    localparam logic [ID_W-1:0] ID_M00  = 6'd25;
    localparam logic [ID_W-1:0] ID_M01  = 6'd26;
    localparam logic [ID_W-1:0] ID_M02  = 6'd27;
    localparam logic [ID_W-1:0] ID_M10  = 6'd28;
    localparam logic [ID_W-1:0] ID_M11  = 6'd29;
    localparam logic [ID_W-1:0] ID_M12  = 6'd30;
    localparam logic [ID_W-1:0] ID_M21  = 6'd31;
    localparam logic [ID_W-1:0] ID_M22  = 6'd32;
    localparam logic [ID_W-1:0] ID_ACC  = 6'd33;
    localparam int ID_COUNT = 34;

    // what to do with a product
    localparam logic [KIND_W-1:0] K_FADD    = 4'd0;
    localparam logic [KIND_W-1:0] K_FSUB    = 4'd1;
    localparam logic [KIND_W-1:0] K_FSET    = 4'd2;
    localparam logic [KIND_W-1:0] K_FSUBSAT = 4'd3;
    localparam logic [KIND_W-1:0] K_TSET    = 4'd4;
    localparam logic [KIND_W-1:0] K_TADD    = 4'd5;
    localparam logic [KIND_W-1:0] K_TSUB    = 4'd6;
    localparam logic [KIND_W-1:0] K_TNEG    = 4'd7;
    localparam logic [KIND_W-1:0] K_RSET    = 4'd8;
    localparam logic [KIND_W-1:0] K_RADD    = 4'd9;
    localparam logic [KIND_W-1:0] K_RFIN    = 4'd10;

    localparam logic [STEP_W-1:0] PROG_CROSS  = 6'd2;
    localparam logic [STEP_W-1:0] PROG_MATRIX = 6'd11;
    localparam logic [STEP_W-1:0] PROG_LAST   = 6'd38;

    typedef struct packed {
        logic        [31:0] sample_time;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] forward_speed;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic               rate_valid;
    } t_in;

    typedef struct packed {
        logic        [31:0] out_time;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
    } t_res;

    typedef struct packed {
        logic               prime;
        logic        [31:0] sample_time;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] forward_speed;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
        logic               rate_valid;
    } t_job;

    typedef struct packed {
        logic               start;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } t_trig_req;

    typedef struct packed {
        logic                   done;
        logic signed [ANG_W-1:0] sa;
        logic signed [ANG_W-1:0] ca;
        logic signed [ANG_W-1:0] sb;
        logic signed [ANG_W-1:0] cb;
        logic signed [ANG_W-1:0] sg;
        logic signed [ANG_W-1:0] cg;
    } t_trig;

    typedef struct packed {
        logic [ID_W-1:0]   a;
        logic [ID_W-1:0]   b;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   dst;
    } t_uop;

    function automatic logic signed [ANG_W-1:0] atan_val(input logic [4:0] i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            5'd0:    v = 34'sd421657428;
            5'd1:    v = 34'sd248918915;
            5'd2:    v = 34'sd131521918;
            5'd3:    v = 34'sd66762579;
            5'd4:    v = 34'sd33510843;
            5'd5:    v = 34'sd16771758;
            5'd6:    v = 34'sd8387925;
            5'd7:    v = 34'sd4194219;
            5'd8:    v = 34'sd2097141;
            5'd9:    v = 34'sd1048575;
            5'd10:   v = 34'sd524288;
            5'd11:   v = 34'sd262144;
            5'd12:   v = 34'sd131072;
            5'd13:   v = 34'sd65536;
            5'd14:   v = 34'sd32768;
            5'd15:   v = 34'sd16384;
            5'd16:   v = 34'sd8192;
            5'd17:   v = 34'sd4096;
            5'd18:   v = 34'sd2048;
            5'd19:   v = 34'sd1024;
            5'd20:   v = 34'sd512;
            5'd21:   v = 34'sd256;
            5'd22:   v = 34'sd128;
            5'd23:   v = 34'sd64;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // clamp to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
            r = v[31:0];
        end else if (v[ACC_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7fff_ffff;
        end
        return r;
    endfunction

    // microcode of one dead reckoning step: operand a, operand b, use, destination
    function automatic t_uop prog(input logic [STEP_W-1:0] s);
        t_uop u;
        unique case (s)
            6'd0:    u = '{ID_DT,  ID_ACCY, K_FADD,    ID_VY};
            6'd1:    u = '{ID_DT,  ID_ACCZ, K_FADD,    ID_VZ};
            6'd2:    u = '{ID_WY,  ID_VZ,   K_FSET,    ID_ACC};
            6'd3:    u = '{ID_WZ,  ID_VY,   K_FSUBSAT, ID_CX};
            6'd4:    u = '{ID_WZ,  ID_VX,   K_FSET,    ID_ACC};
            6'd5:    u = '{ID_WX,  ID_VZ,   K_FSUBSAT, ID_CY};
            6'd6:    u = '{ID_WX,  ID_VY,   K_FSET,    ID_ACC};
            6'd7:    u = '{ID_WY,  ID_VX,   K_FSUBSAT, ID_CZ};
            6'd8:    u = '{ID_DT,  ID_CX,   K_FSUB,    ID_VX};
            6'd9:    u = '{ID_DT,  ID_CY,   K_FSUB,    ID_VY};
            6'd10:   u = '{ID_DT,  ID_CZ,   K_FSUB,    ID_VZ};
            6'd11:   u = '{ID_CG,  ID_SA,   K_TSET,    ID_T};
            6'd12:   u = '{ID_T,   ID_SB,   K_TSET,    ID_M01};
            6'd13:   u = '{ID_CA,  ID_SG,   K_TADD,    ID_M01};
            6'd14:   u = '{ID_CA,  ID_CG,   K_TSET,    ID_T};
            6'd15:   u = '{ID_T,   ID_SB,   K_TNEG,    ID_M02};
            6'd16:   u = '{ID_SA,  ID_SG,   K_TADD,    ID_M02};
            6'd17:   u = '{ID_SA,  ID_SB,   K_TSET,    ID_T};
            6'd18:   u = '{ID_CA,  ID_CG,   K_TSET,    ID_M11};
            6'd19:   u = '{ID_T,   ID_SG,   K_TSUB,    ID_M11};
            6'd20:   u = '{ID_CA,  ID_SB,   K_TSET,    ID_T};
            6'd21:   u = '{ID_T,   ID_SG,   K_TSET,    ID_M12};
            6'd22:   u = '{ID_CG,  ID_SA,   K_TADD,    ID_M12};
            6'd23:   u = '{ID_CB,  ID_CG,   K_TSET,    ID_M00};
            6'd24:   u = '{ID_CB,  ID_SG,   K_TNEG,    ID_M10};
            6'd25:   u = '{ID_CB,  ID_SA,   K_TNEG,    ID_M21};
            6'd26:   u = '{ID_CA,  ID_CB,   K_TSET,    ID_M22};
            6'd27:   u = '{ID_M00, ID_VX,   K_RSET,    ID_ACC};
            6'd28:   u = '{ID_M01, ID_VY,   K_RADD,    ID_ACC};
            6'd29:   u = '{ID_M02, ID_VZ,   K_RFIN,    ID_RX};
            6'd30:   u = '{ID_M10, ID_VX,   K_RSET,    ID_ACC};
            6'd31:   u = '{ID_M11, ID_VY,   K_RADD,    ID_ACC};
            6'd32:   u = '{ID_M12, ID_VZ,   K_RFIN,    ID_RY};
            6'd33:   u = '{ID_SB,  ID_VX,   K_RSET,    ID_ACC};
            6'd34:   u = '{ID_M21, ID_VY,   K_RADD,    ID_ACC};
            6'd35:   u = '{ID_M22, ID_VZ,   K_RFIN,    ID_RZ};
            6'd36:   u = '{ID_DT,  ID_RX,   K_FADD,    ID_PX};
            6'd37:   u = '{ID_DT,  ID_RY,   K_FSUB,    ID_PY};
            6'd38:   u = '{ID_DT,  ID_RZ,   K_FSUB,    ID_PZ};
            default: u = '{ID_DT,  ID_DT,   K_RSET,    ID_ACC};
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/core/idr_front.sv -----
// Front end: configuration register, first-sample marking and gravity removal.
module idr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [idr_pkg::GRAV_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  idr_pkg::t_in                  i_in,
    input  logic                          i_q_full,
    output logic                          o_push,
    output idr_pkg::t_job                 o_job
);

    logic [idr_pkg::GRAV_W-1:0]       r_gravity;
    logic                             r_primed;
    logic signed [idr_pkg::ACC_W-1:0] accz_diff;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign o_push      = i_in_valid && !i_q_full;

    assign accz_diff = {{(idr_pkg::ACC_W-32){i_in.accel_z[31]}}, i_in.accel_z}
                     - {{(idr_pkg::ACC_W-idr_pkg::GRAV_W){1'b0}}, r_gravity};

    always_comb begin
        o_job.prime         = !r_primed;
        o_job.sample_time   = i_in.sample_time;
        o_job.angle_x       = i_in.angle_x;
        o_job.angle_y       = i_in.angle_y;
        o_job.angle_z       = i_in.angle_z;
        o_job.accel_y       = i_in.accel_y;
        o_job.accel_z       = idr_pkg::sat32(accz_diff);
        o_job.forward_speed = i_in.forward_speed;
        o_job.rate_x        = i_in.rate_x;
        o_job.rate_y        = i_in.rate_y;
        o_job.rate_z        = i_in.rate_z;
        o_job.rate_valid    = i_in.rate_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= idr_pkg::GRAVITY_RESET;
            r_primed  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_gravity <= i_cfg_data;
            end
            if (o_push) begin
                r_primed <= 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/idr_queue.sv -----
// Two-entry job queue between front end and back end.
module idr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  idr_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output idr_pkg::t_job o_job,
    input  logic          i_pop
);

    idr_pkg::t_job                r_mem [idr_pkg::QUEUE_DEPTH];
    logic [idr_pkg::QPTR_W-1:0]   r_wp;
    logic [idr_pkg::QPTR_W-1:0]   r_rp;
    logic [idr_pkg::QCNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == idr_pkg::QCNT_W'(idr_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    function automatic logic [idr_pkg::QPTR_W-1:0] ptr_inc(input logic [idr_pkg::QPTR_W-1:0] p);
        logic [idr_pkg::QPTR_W-1:0] r;
        if (p == idr_pkg::QPTR_W'(idr_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/idr_cordic.sv -----
// Three-lane iterative rotation CORDIC giving sine and cosine of the stored angles.
module idr_cordic #(
    parameter int TRIG_ITERATIONS = idr_pkg::TRIG_ITER_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  idr_pkg::t_trig_req i_req,
    output idr_pkg::t_trig     o_trig
);

    localparam int ITERS = (TRIG_ITERATIONS < idr_pkg::ATAN_COUNT) ?
                           TRIG_ITERATIONS : idr_pkg::ATAN_COUNT;
    localparam int CNT_W = $clog2(ITERS + 1);
    localparam int AW    = idr_pkg::ANG_W;

    logic signed [AW-1:0] r_x [3];
    logic signed [AW-1:0] r_y [3];
    logic signed [AW-1:0] r_z [3];
    logic [2:0]           r_flip;
    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;

    logic signed [15:0]   ang    [3];
    logic signed [AW-1:0] z0     [3];
    logic [2:0]           flip0;
    logic signed [AW-1:0] n_x    [3];
    logic signed [AW-1:0] n_y    [3];
    logic signed [AW-1:0] n_z    [3];
    logic signed [AW-1:0] atan_i;

    assign ang[0] = i_req.angle_x;
    assign ang[1] = i_req.angle_y;
    assign ang[2] = i_req.angle_z;
    assign atan_i = idr_pkg::atan_val(5'(r_cnt));

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic signed [AW-1:0] zs;
            zs = {{(AW-32){ang[l][15]}}, ang[l], 16'b0};
            // fold angles beyond a quarter turn back by half a turn
            if (zs > idr_pkg::ANG_HALF_PI) begin
                z0[l]    = zs - idr_pkg::ANG_PI;
                flip0[l] = 1'b1;
            end else if (zs < -idr_pkg::ANG_HALF_PI) begin
                z0[l]    = zs + idr_pkg::ANG_PI;
                flip0[l] = 1'b1;
            end else begin
                z0[l]    = zs;
                flip0[l] = 1'b0;
            end
            if (!r_z[l][AW-1]) begin
                n_x[l] = r_x[l] - (r_y[l] >>> r_cnt);
                n_y[l] = r_y[l] + (r_x[l] >>> r_cnt);
                n_z[l] = r_z[l] - atan_i;
            end else begin
                n_x[l] = r_x[l] + (r_y[l] >>> r_cnt);
                n_y[l] = r_y[l] - (r_x[l] >>> r_cnt);
                n_z[l] = r_z[l] + atan_i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            if (i_req.start) begin
                r_x[l]    <= idr_pkg::CORDIC_GAIN;
                r_y[l]    <= '0;
                r_z[l]    <= z0[l];
                r_flip[l] <= flip0[l];
            end else if (r_busy) begin
                r_x[l] <= n_x[l];
                r_y[l] <= n_y[l];
                r_z[l] <= n_z[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ITERS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_trig.done = !r_busy && !i_req.start;
    assign o_trig.sa   = r_flip[0] ? -r_y[0] : r_y[0];
    assign o_trig.ca   = r_flip[0] ? -r_x[0] : r_x[0];
    assign o_trig.sb   = r_flip[1] ? -r_y[1] : r_y[1];
    assign o_trig.cb   = r_flip[1] ? -r_x[1] : r_x[1];
    assign o_trig.sg   = r_flip[2] ? -r_y[2] : r_y[2];
    assign o_trig.cg   = r_flip[2] ? -r_x[2] : r_x[2];

endmodule

// ----- rtl/core/idr_back.sv -----
// Back end: microcoded sequencer around one shared multiplier, state and result register.
module idr_back #(
    parameter int FRAC_BITS = idr_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  idr_pkg::t_job      i_job,
    output logic               o_job_pop,
    output idr_pkg::t_trig_req o_trig_req,
    input  idr_pkg::t_trig     i_trig,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output idr_pkg::t_res      o_out
);

    localparam int AW = idr_pkg::ANG_W;
    localparam int PW = idr_pkg::PROD_W;
    localparam int CW = idr_pkg::ACC_W;
    localparam int SW = idr_pkg::STEP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_step,  n_step;
    logic          r_phase, n_phase;

    idr_pkg::t_job      r_job;
    logic signed [31:0] r_dt;
    logic        [31:0] r_prev_time;
    logic signed [15:0] r_prev_ax, r_prev_ay, r_prev_az;
    logic signed [31:0] r_vx, r_vy, r_vz, r_px, r_py, r_pz;
    logic signed [31:0] r_cx, r_cy, r_cz, r_rx, r_ry, r_rz;
    logic signed [AW-1:0] r_t, r_m00, r_m01, r_m02, r_m10, r_m11, r_m12, r_m21, r_m22;
    logic signed [CW-1:0] r_acc;
    logic signed [PW-1:0] r_prod;
    idr_pkg::t_uop        r_uop;

    logic          r_ovalid;
    idr_pkg::t_res r_ores;

    logic out_free, take_prime, take_step, issue, consume, load_done, trig_wait;
    idr_pkg::t_uop uop_cur;

    logic signed [AW-1:0] v_src [idr_pkg::ID_COUNT];
    logic signed [AW-1:0] op_a, op_b, dcur;
    logic signed [PW-1:0] prod, pf, pt;
    logic signed [CW-1:0] pf70, p70, d70, rsum;
    logic signed [31:0]   w32;
    logic signed [AW-1:0] w34;
    logic signed [CW-1:0] acc_n;
    logic                 we32, we34, wacc;

    function automatic logic signed [AW-1:0] ext32(input logic signed [31:0] v);
        return {{(AW-32){v[31]}}, v};
    endfunction

    // operand view of every register the microcode may name
    always_comb begin
        v_src[idr_pkg::ID_DT]   = ext32(r_dt);
        v_src[idr_pkg::ID_ACCY] = ext32(r_job.accel_y);
        v_src[idr_pkg::ID_ACCZ] = ext32(r_job.accel_z);
        v_src[idr_pkg::ID_WX]   = ext32(r_job.rate_x);
        v_src[idr_pkg::ID_WY]   = ext32(r_job.rate_y);
        v_src[idr_pkg::ID_WZ]   = ext32(r_job.rate_z);
        v_src[idr_pkg::ID_VX]   = ext32(r_vx);
        v_src[idr_pkg::ID_VY]   = ext32(r_vy);
        v_src[idr_pkg::ID_VZ]   = ext32(r_vz);
        v_src[idr_pkg::ID_CX]   = ext32(r_cx);
        v_src[idr_pkg::ID_CY]   = ext32(r_cy);
        v_src[idr_pkg::ID_CZ]   = ext32(r_cz);
        v_src[idr_pkg::ID_RX]   = ext32(r_rx);
        v_src[idr_pkg::ID_RY]   = ext32(r_ry);
        v_src[idr_pkg::ID_RZ]   = ext32(r_rz);
        v_src[idr_pkg::ID_PX]   = ext32(r_px);
        v_src[idr_pkg::ID_PY]   = ext32(r_py);
        v_src[idr_pkg::ID_PZ]   = ext32(r_pz);
        v_src[idr_pkg::ID_SA]   = i_trig.sa;
        v_src[idr_pkg::ID_CA]   = i_trig.ca;
        v_src[idr_pkg::ID_SB]   = i_trig.sb;
        v_src[idr_pkg::ID_CB]   = i_trig.cb;
        v_src[idr_pkg::ID_SG]   = i_trig.sg;
        v_src[idr_pkg::ID_CG]   = i_trig.cg;
        v_src[idr_pkg::ID_T]    = r_t;
        v_src[idr_pkg::ID_M00]  = r_m00;
        v_src[idr_pkg::ID_M01]  = r_m01;
        v_src[idr_pkg::ID_M02]  = r_m02;
        v_src[idr_pkg::ID_M10]  = r_m10;
        v_src[idr_pkg::ID_M11]  = r_m11;
        v_src[idr_pkg::ID_M12]  = r_m12;
        v_src[idr_pkg::ID_M21]  = r_m21;
        v_src[idr_pkg::ID_M22]  = r_m22;
        v_src[idr_pkg::ID_ACC]  = r_acc[AW-1:0];
    end

    assign uop_cur = idr_pkg::prog(r_step);
    assign op_a    = v_src[uop_cur.a];
    assign op_b    = v_src[uop_cur.b];
    assign prod    = op_a * op_b;

    assign pf   = r_prod >>> FRAC_BITS;
    assign pt   = r_prod >>> idr_pkg::TRIG_SHIFT;
    assign pf70 = {{(CW-PW){pf[PW-1]}}, pf};
    assign p70  = {{(CW-PW){r_prod[PW-1]}}, r_prod};
    assign dcur = v_src[r_uop.dst];
    assign d70  = {{(CW-AW){dcur[AW-1]}}, dcur};
    assign rsum = (r_acc + p70) >>> idr_pkg::TRIG_SHIFT;

    always_comb begin
        w32   = '0;
        w34   = '0;
        acc_n = r_acc;
        we32  = 1'b0;
        we34  = 1'b0;
        wacc  = 1'b0;
        unique case (r_uop.kind)
            idr_pkg::K_FADD: begin
                w32 = idr_pkg::sat32(d70 + pf70);
                we32 = 1'b1;
            end
            idr_pkg::K_FSUB: begin
                w32 = idr_pkg::sat32(d70 - pf70);
                we32 = 1'b1;
            end
            idr_pkg::K_FSUBSAT: begin
                w32 = idr_pkg::sat32(r_acc - pf70);
                we32 = 1'b1;
            end
            idr_pkg::K_FSET: begin
                acc_n = pf70;
                wacc  = 1'b1;
            end
            idr_pkg::K_TSET: begin
                w34  = pt[AW-1:0];
                we34 = 1'b1;
            end
            idr_pkg::K_TADD: begin
                w34  = dcur + pt[AW-1:0];
                we34 = 1'b1;
            end
            idr_pkg::K_TSUB: begin
                w34  = dcur - pt[AW-1:0];
                we34 = 1'b1;
            end
            idr_pkg::K_TNEG: begin
                w34  = -pt[AW-1:0];
                we34 = 1'b1;
            end
            idr_pkg::K_RSET: begin
                acc_n = p70;
                wacc  = 1'b1;
            end
            idr_pkg::K_RADD: begin
                acc_n = r_acc + p70;
                wacc  = 1'b1;
            end
            idr_pkg::K_RFIN: begin
                w32  = idr_pkg::sat32(rsum);
                we32 = 1'b1;
            end
            default: begin
                wacc = 1'b0;
            end
        endcase
    end

    assign out_free  = !r_ovalid || i_out_ready;
    assign trig_wait = (r_step == idr_pkg::PROG_MATRIX) && !i_trig.done;

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_phase    = r_phase;
        take_prime = 1'b0;
        take_step  = 1'b0;
        issue      = 1'b0;
        consume    = 1'b0;
        load_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.prime) begin
                        take_prime = out_free;
                    end else begin
                        take_step = 1'b1;
                        n_state   = ST_RUN;
                        n_step    = '0;
                        n_phase   = 1'b0;
                    end
                end
            end
            ST_RUN: begin
                if (!r_phase) begin
                    if (!trig_wait) begin
                        issue   = 1'b1;
                        n_phase = 1'b1;
                    end
                end else begin
                    consume = 1'b1;
                    n_phase = 1'b0;
                    if (r_step == idr_pkg::PROG_LAST) begin
                        n_state = ST_HOLD;
                    end else if ((r_step == idr_pkg::PROG_CROSS - 1'b1) &&
                                 !r_job.rate_valid) begin
                        n_step = idr_pkg::PROG_MATRIX;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    load_done = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_job_pop          = take_prime || take_step;
    assign o_trig_req.start   = take_step;
    assign o_trig_req.angle_x = r_prev_ax;
    assign o_trig_req.angle_y = r_prev_ay;
    assign o_trig_req.angle_z = r_prev_az;

    // control, stored model state and result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_phase     <= 1'b0;
            r_ovalid    <= 1'b0;
            r_prev_time <= '0;
            r_prev_ax   <= '0;
            r_prev_ay   <= '0;
            r_prev_az   <= '0;
            r_vx        <= '0;
            r_vy        <= '0;
            r_vz        <= '0;
            r_px        <= '0;
            r_py        <= '0;
            r_pz        <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_phase <= n_phase;
            if (o_job_pop) begin
                r_prev_time <= i_job.sample_time;
                r_prev_ax   <= i_job.angle_x;
                r_prev_ay   <= i_job.angle_y;
                r_prev_az   <= i_job.angle_z;
            end
            if (take_step) begin
                r_vx <= i_job.forward_speed;
            end
            if (consume && we32) begin
                priority case (r_uop.dst)
                    idr_pkg::ID_VX: r_vx <= w32;
                    idr_pkg::ID_VY: r_vy <= w32;
                    idr_pkg::ID_VZ: r_vz <= w32;
                    idr_pkg::ID_PX: r_px <= w32;
                    idr_pkg::ID_PY: r_py <= w32;
                    idr_pkg::ID_PZ: r_pz <= w32;
                    default: begin
                    end
                endcase
            end
            if (take_prime || load_done) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers, no reset
    always_ff @(posedge i_clk) begin
        if (take_step) begin
            r_job <= i_job;
            r_dt  <= i_job.sample_time - r_prev_time;
        end
        if (issue) begin
            r_prod <= prod;
            r_uop  <= uop_cur;
        end
        if (consume && wacc) begin
            r_acc <= acc_n;
        end
        if (consume && we32) begin
            priority case (r_uop.dst)
                idr_pkg::ID_CX: r_cx <= w32;
                idr_pkg::ID_CY: r_cy <= w32;
                idr_pkg::ID_CZ: r_cz <= w32;
                idr_pkg::ID_RX: r_rx <= w32;
                idr_pkg::ID_RY: r_ry <= w32;
                idr_pkg::ID_RZ: r_rz <= w32;
                default: begin
                end
            endcase
        end
        if (consume && we34) begin
            priority case (r_uop.dst)
                idr_pkg::ID_T:   r_t   <= w34;
                idr_pkg::ID_M00: r_m00 <= w34;
                idr_pkg::ID_M01: r_m01 <= w34;
                idr_pkg::ID_M02: r_m02 <= w34;
                idr_pkg::ID_M10: r_m10 <= w34;
                idr_pkg::ID_M11: r_m11 <= w34;
                idr_pkg::ID_M12: r_m12 <= w34;
                idr_pkg::ID_M21: r_m21 <= w34;
                idr_pkg::ID_M22: r_m22 <= w34;
                default: begin
                end
            endcase
        end
        if (take_prime) begin
            r_ores <= '{i_job.sample_time, 32'sd0, 32'sd0, 32'sd0};
        end else if (load_done) begin
            r_ores <= '{r_job.sample_time, r_px, r_py, r_pz};
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_ores;

endmodule

// ----- rtl/core/inertial_dead_reckoning_step_unit.sv -----
// Top level of the strapdown dead reckoning unit: front end, job queue, CORDIC and back end.
//
//   channel   direction  handshake                     word
//   cfg       in         i_cfg_valid / o_cfg_ready     gravity, 21 bit unsigned Q5.16
//   in        in         i_in_valid  / o_in_ready      one sensor sample (t_in)
//   out       out        o_out_valid / i_out_ready     time and position (t_res)
//
// A priming sample goes straight to the output register with zero position. A full sample
// runs the microcode steps, each with an issue and a consume phase on the one shared 34x34
// multiplier; without rates the cross steps are skipped and the CORDIC sets the wait
// before the matrix steps. Reset clears control and model state only; no sweep.
// The two-entry queue lets the front take samples while the back works, and the output
// register lets the back start the next sample while a result waits to be taken.
module inertial_dead_reckoning_step_unit #(
    parameter int FRAC_BITS       = idr_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = idr_pkg::TRIG_ITER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [idr_pkg::GRAV_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  idr_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output idr_pkg::t_res              o_out
);

    // front to queue
    logic               q_push;
    logic               q_full;
    idr_pkg::t_job      q_in_job;
    // queue to back
    logic               q_valid;
    logic               q_pop;
    idr_pkg::t_job      q_out_job;
    // back and CORDIC
    idr_pkg::t_trig_req trig_req;
    idr_pkg::t_trig     trig;

    // classify and condition each word, mark the first one after reset
    idr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_in_job)
    );

    // hold jobs until the back end is free
    idr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out_job),
        .i_pop   (q_pop)
    );

    // sine and cosine of the previous sample's angles, three lanes at once
    idr_cordic #(
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (trig_req),
        .o_trig  (trig)
    );

    // velocity, rotation and position integration
    idr_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_out_job),
        .o_job_pop   (q_pop),
        .o_trig_req  (trig_req),
        .i_trig      (trig),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // the back end only drains a queue that holds a job
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("job popped from empty queue");

    // a CORDIC start always leaves the unit busy on the next cycle
    a_cordic_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig_req.start |=> !trig.done)
        else $error("CORDIC reports done right after start");

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// ----- dv/inertial_dead_reckoning_step_unit_tb.sv -----
// Testbench for the dead reckoning step unit: random and directed samples checked by a scoreboard.
`timescale 1ns / 100ps

module inertial_dead_reckoning_step_unit_tb;

    typedef logic signed [127:0] t_wide;

    localparam int FB    = 16;
    localparam int TITER = 16;
    localparam int IN_W  = $bits(idr_pkg::t_in);

    // Track the block's state and hold the positions it should emit, oldest first.
    class dr_scoreboard;
        logic [20:0]        gravity;
        bit                 primed;
        logic [31:0]        last_time;
        logic signed [15:0] last_ax, last_ay, last_az;
        t_wide              vx, vy, vz, px, py, pz;
        idr_pkg::t_res      pending[$];
        int                 errors;
        t_wide              atan_steps[24];

        function new();
            atan_steps = '{421657428, 248918915, 131521918, 66762579, 33510843,
                16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144,
                131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                128, 64};
            gravity = idr_pkg::GRAVITY_RESET;
            primed = 0;
            last_time = 0;
            last_ax = 0; last_ay = 0; last_az = 0;
            vx = 0; vy = 0; vz = 0; px = 0; py = 0; pz = 0;
            errors = 0;
        endfunction

        function t_wide clamp(t_wide v);
            if (v > 128'sd2147483647) return 128'sd2147483647;
            if (v < -128'sd2147483648) return -128'sd2147483648;
            return v;
        endfunction

        function t_wide qmul(t_wide a, t_wide b);
            return (a * b) >>> FB;
        endfunction

        function t_wide trmul(t_wide a, t_wide b);
            return (a * b) >>> idr_pkg::TRIG_SHIFT;
        endfunction

        task sincos(logic signed [15:0] ang, output t_wide s, output t_wide c);
            t_wide z, x, y, dx, dy;
            bit    flip;
            z = t_wide'(ang) * 65536;
            x = idr_pkg::CORDIC_GAIN;
            y = 0;
            flip = 0;
            if (z > t_wide'(idr_pkg::ANG_HALF_PI)) begin
                z = z - t_wide'(idr_pkg::ANG_PI);
                flip = 1;
            end else if (z < -t_wide'(idr_pkg::ANG_HALF_PI)) begin
                z = z + t_wide'(idr_pkg::ANG_PI);
                flip = 1;
            end
            for (int i = 0; i < TITER && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - atan_steps[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + atan_steps[i];
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endtask

        function t_wide rotate_row(t_wide m0, t_wide m1, t_wide m2);
            return clamp((m0 * vx + m1 * vy + m2 * vz) >>> idr_pkg::TRIG_SHIFT);
        endfunction

        // Advance the state by one accepted sample and queue its position.
        task note_sample(idr_pkg::t_in s);
            idr_pkg::t_res r;
            t_wide dt, ay, az, cx, cy, cz, sa, ca, sb, cb, sg, cg, rx, ry, rz;
            ay = t_wide'(s.accel_y);
            az = clamp(t_wide'(s.accel_z) - t_wide'({1'b0, gravity}));
            r.out_time = s.sample_time;
            if (primed) begin
                dt = t_wide'($signed(s.sample_time - last_time));
                vx = t_wide'(s.forward_speed);
                vy = clamp(vy + qmul(dt, ay));
                vz = clamp(vz + qmul(dt, az));
                if (s.rate_valid) begin
                    cx = clamp(qmul(t_wide'(s.rate_y), vz) - qmul(t_wide'(s.rate_z), vy));
                    cy = clamp(qmul(t_wide'(s.rate_z), vx) - qmul(t_wide'(s.rate_x), vz));
                    cz = clamp(qmul(t_wide'(s.rate_x), vy) - qmul(t_wide'(s.rate_y), vx));
                    vx = clamp(vx - qmul(dt, cx));
                    vy = clamp(vy - qmul(dt, cy));
                    vz = clamp(vz - qmul(dt, cz));
                end
                sincos(last_ax, sa, ca);
                sincos(last_ay, sb, cb);
                sincos(last_az, sg, cg);
                rx = rotate_row(trmul(cb, cg),
                                trmul(ca, sg) + trmul(trmul(cg, sa), sb),
                                trmul(sa, sg) - trmul(trmul(ca, cg), sb));
                ry = rotate_row(-trmul(cb, sg),
                                trmul(ca, cg) - trmul(trmul(sa, sb), sg),
                                trmul(cg, sa) + trmul(trmul(ca, sb), sg));
                rz = rotate_row(sb, -trmul(cb, sa), trmul(ca, cb));
                px = clamp(px + qmul(dt, rx));
                py = clamp(py - qmul(dt, ry));
                pz = clamp(pz - qmul(dt, rz));
                r.out_x = px[31:0];
                r.out_y = py[31:0];
                r.out_z = pz[31:0];
            end else begin
                primed = 1;
                r.out_x = 0; r.out_y = 0; r.out_z = 0;
            end
            last_time = s.sample_time;
            last_ax = s.angle_x; last_ay = s.angle_y; last_az = s.angle_z;
            pending = {pending, r};
        endtask

        task check_result(idr_pkg::t_res got);
            idr_pkg::t_res want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.out_time !== want.out_time) begin
                $display("%0t: out_time expected %h actual %h", $time, want.out_time,
                         got.out_time);
                errors++;
            end
            if (got.out_x !== want.out_x) begin
                $display("%0t: out_x expected %h actual %h", $time, want.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== want.out_y) begin
                $display("%0t: out_y expected %h actual %h", $time, want.out_y, got.out_y);
                errors++;
            end
            if (got.out_z !== want.out_z) begin
                $display("%0t: out_z expected %h actual %h", $time, want.out_z, got.out_z);
                errors++;
            end
        endtask
    endclass

    logic                        i_clk = 0;
    logic                        i_rst_n = 0;
    logic                        i_cfg_valid = 0;
    logic                        o_cfg_ready;
    logic [idr_pkg::GRAV_W-1:0]  i_cfg_data = '0;
    logic                        i_in_valid = 0;
    logic                        o_in_ready;
    idr_pkg::t_in                i_in = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 0;
    idr_pkg::t_res               o_out;

    dr_scoreboard        sb = new();
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    logic [31:0]         clock_now = 0;

    inertial_dead_reckoning_step_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Take results at random; check every word accepted.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold a word on the input channel until accepted; idle first at random.
    task send_sample(idr_pkg::t_in s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_sample(s);
    endtask

    // Write gravity once the block has drained.
    task write_gravity(logic [idr_pkg::GRAV_W-1:0] g);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= g;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.gravity = g;
    endtask

    function automatic logic [31:0] small_q(int mag);
        return $unsigned($signed($urandom_range(2 * mag)) - mag);
    endfunction

    // Mostly plausible motion with a short forward time step; sometimes raw noise.
    function automatic idr_pkg::t_in random_sample();
        idr_pkg::t_in s;
        if ($urandom_range(9) == 0) begin
            s = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom});
            clock_now = s.sample_time;
        end else begin
            clock_now = clock_now + $urandom_range(($urandom_range(19) == 0) ? 65536 : 3300);
            s.sample_time   = clock_now;
            s.angle_x       = 16'(small_q(($urandom_range(3) == 0) ? 32768 : 4000));
            s.angle_y       = 16'(small_q(($urandom_range(3) == 0) ? 32768 : 4000));
            s.angle_z       = 16'(small_q(($urandom_range(3) == 0) ? 32768 : 4000));
            s.accel_y       = small_q(1500000);
            s.accel_z       = 642908 + small_q(1500000);
            s.forward_speed = small_q(3000000);
            s.rate_x        = small_q(200000);
            s.rate_y        = small_q(200000);
            s.rate_z        = small_q(200000);
            s.rate_valid    = 1'($urandom_range(1));
        end
        return s;
    endfunction

    function automatic idr_pkg::t_in directed(logic [31:0] t, logic signed [15:0] a,
                                              logic signed [31:0] v, logic rv);
        idr_pkg::t_in s;
        s = {t, a, -a, a, v, v, v, v, -v, v, rv};
        return s;
    endfunction

    initial begin
        #5000000;
        $display("inertial_dead_reckoning_step_unit test failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: priming sample, angles just past the quarter turn, extremes,
        // a backward time step and a wrapping one, rates on and off.
        send_sample(directed(32'd1000, 16'sd0, 32'sd0, 1'b0));
        send_sample(directed(32'd4000, 16'sd12868, 32'sd65536, 1'b1));
        send_sample(directed(32'd7000, 16'sd12869, 32'sd131072, 1'b1));
        send_sample(directed(32'd9000, -16'sd12869, -32'sd65536, 1'b0));
        send_sample(directed(32'd12000, 16'sh7fff, 32'sh7fff_ffff, 1'b1));
        send_sample(directed(32'd15000, 16'sh8000, 32'sh8000_0000, 1'b1));
        send_sample(directed(32'd2000, 16'sd3000, 32'sd500000, 1'b1));
        send_sample(directed(32'hffff_ff00, -16'sd3000, 32'sd0, 1'b0));
        send_sample(directed(32'h0000_0100, 16'sd25000, -32'sd900000, 1'b1));
        send_sample(directed(32'h8000_0000, 16'sh7fff, 32'sh7fff_ffff, 1'b1));
        send_sample(directed(32'h0000_0000, 16'sh8000, 32'sh8000_0000, 1'b1));
        send_sample(directed(32'h0000_1000, 16'sd0, 32'sd0, 1'b0));
        write_gravity(21'd0);
        send_sample(directed(32'h0000_2000, 16'sd100, 32'sd65536, 1'b0));
        write_gravity(21'd1048576);
        send_sample(directed(32'h0000_3000, -16'sd100, -32'sd65536, 1'b1));
        clock_now = 32'h0000_3000;

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 79 : 0;
            recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 24 : 0;
            write_gravity((phase == 0) ? idr_pkg::GRAVITY_RESET :
                          (phase == 1) ? 21'($urandom_range(1048576)) : 21'd1048576);
            for (int k = 0; k < 400; k++) send_sample(random_sample());
        end
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("inertial_dead_reckoning_step_unit test passed");
        end else begin
            $display("inertial_dead_reckoning_step_unit test failed");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/idr_pkg.sv
rtl/core/idr_front.sv
rtl/core/idr_queue.sv
rtl/core/idr_cordic.sv
rtl/core/idr_back.sv
rtl/core/inertial_dead_reckoning_step_unit.sv
dv/inertial_dead_reckoning_step_unit_tb.sv
